>>> hdl/dht_pkg.sv
// Shared types and codes for the double-hashing insert/delete table.
package dht_pkg;

	localparam int KEY_W   = 31;
	localparam int SLOT_W  = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] OUT_INSERTED  = 2'd0;
	localparam logic [1:0] OUT_FULL      = 2'd1;
	localparam logic [1:0] OUT_DELETED   = 2'd2;
	localparam logic [1:0] OUT_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic del;
	} mem_op_t;

endpackage

>>> hdl/double_hash_table_insert_delete_top.sv
// Top level: open-addressing hash table with double hashing, insert and delete.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   command (0 insert, 1 delete) and key are sampled there.
//   Exactly one result follows: done is high for one cycle with outcome
//   (inserted, full, deleted, not found) and slot (low 4 bits of the index,
//   0 for full or not found). The receiver cannot stall; results are not held.
//   The key is folded by bytes at the accepting edge and reduced by
//   reciprocal multiplication, the quotient and then the remainder being
//   registered; the first memory read follows, then the probes, 1 to
//   TABLE_SIZE of them, one after another on the single slot memory port.
//   busy falls in the done cycle, so a new transaction can be taken at the
//   edge that ends it; none is taken while one is in progress.
//   Reset clears all valid bits, so every slot reads as empty; no clearing
//   pass is needed and start is taken right after reset.
module double_hash_table_insert_delete_top #(
	parameter int TABLE_SIZE = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [dht_pkg::KEY_W-1:0]     key,
	output logic                          done,
	output logic [1:0]                    outcome,
	output logic [dht_pkg::SLOT_W-1:0]    slot
);
	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);

	state_t             state_q;
	state_t             state_d;
	logic               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   step_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               done_q;
	logic [1:0]         outcome_q;
	logic [SLOT_W-1:0]  slot_q;

	logic               accept;
	logic               hash_done;
	logic [IDX_W-1:0]   home;
	logic [IDX_W-1:0]   step;
	mem_op_t            op;
	logic [IDX_W-1:0]   addr;
	logic [KEY_W-1:0]   rd_key;
	logic               rd_del;
	logic               rd_vld;

	logic               occupied;
	logic               hit;
	logic               stop;
	logic               last;
	logic               finish;
	logic [1:0]         outcome_d;
	logic [IDX_W:0]     sum;
	logic [IDX_W-1:0]   idx_next;
	logic [IDX_W+3:0]   idx_ext;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	dht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.key    (key),
		.done   (hash_done),
		.home   (home),
		.step   (step)
	);

	dht_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.addr   (addr),
		.wr_key (key_q),
		.rd_key (rd_key),
		.rd_del (rd_del),
		.rd_vld (rd_vld)
	);

	assign occupied = rd_vld && !rd_del;
	assign last     = (cnt_q == IDX_W'(TABLE_SIZE - 1));
	assign sum      = {1'b0, idx_q} + {1'b0, step_q};
	assign idx_next = (sum >= (IDX_W + 1)'(TABLE_SIZE)) ?
		IDX_W'(sum - (IDX_W + 1)'(TABLE_SIZE)) : sum[IDX_W-1:0];
	assign idx_ext  = (IDX_W + 4)'(idx_q);

	always_comb begin
		if (cmd_q == CMD_INSERT) begin
			hit  = !occupied;
			stop = 1'b0;
		end else begin
			hit  = occupied && (rd_key == key_q);
			stop = !rd_vld;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (hit || stop || last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op        = '0;
		addr      = idx_q;
		finish    = 1'b0;
		outcome_d = OUT_NOT_FOUND;
		case (state_q)
			ST_HASH: begin
				op.rd = hash_done;
				addr  = home;
			end
			ST_PROBE: begin
				if (hit) begin
					finish    = 1'b1;
					op.wr     = 1'b1;
					op.del    = (cmd_q == CMD_DELETE);
					addr      = idx_q;
					outcome_d = (cmd_q == CMD_INSERT) ? OUT_INSERTED : OUT_DELETED;
				end else if (stop || last) begin
					finish    = 1'b1;
					outcome_d = (cmd_q == CMD_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
				end else begin
					op.rd = 1'b1;
					addr  = idx_next;
				end
			end
			default: begin
				op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
		end
		if (state_q == ST_HASH && hash_done) begin
			idx_q  <= home;
			step_q <= step;
			cnt_q  <= '0;
		end else if (state_q == ST_PROBE && !finish) begin
			idx_q <= idx_next;
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (finish) begin
			outcome_q <= outcome_d;
			slot_q    <= (outcome_d == OUT_INSERTED || outcome_d == OUT_DELETED) ?
				idx_ext[SLOT_W-1:0] : '0;
		end
	end

	assign done    = done_q;
	assign outcome = outcome_q;
	assign slot    = slot_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_PROBE))
		else $error("result strobe without a probe");

	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (outcome == OUT_FULL || outcome == OUT_NOT_FOUND)) |-> (slot == '0))
		else $error("nonzero slot on full or not found");

	a_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		op.wr |-> (state_q == ST_PROBE && finish))
		else $error("slot write outside a finishing probe");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (cnt_q <= IDX_W'(TABLE_SIZE - 1)
			&& {1'b0, idx_q} < (IDX_W + 1)'(TABLE_SIZE)))
		else $error("probe count or index out of range");
`endif

endmodule

>>> hdl/dht_hash.sv
// Pipelined reduction of the key to home slot and probe step.
module dht_hash #(
	parameter int TABLE_SIZE = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [dht_pkg::KEY_W-1:0]     key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] home,
	output logic [$clog2(TABLE_SIZE)-1:0] step
);
	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int FW    = 18;
	localparam int RW    = 26;
	localparam int PW    = FW + RW;
	localparam int SH    = FW + 8;
	localparam int MH    = TABLE_SIZE;
	localparam int MS    = TABLE_SIZE - 1;
	localparam int WH1   = (1 << 8) % MH;
	localparam int WH2   = (1 << 16) % MH;
	localparam int WH3   = (1 << 24) % MH;
	localparam int WS1   = (1 << 8) % MS;
	localparam int WS2   = (1 << 16) % MS;
	localparam int WS3   = (1 << 24) % MS;
	localparam int RH    = ((1 << SH) + MH - 1) / MH;
	localparam int RS    = ((1 << SH) + MS - 1) / MS;

	logic [FW-1:0]    fh_s1;
	logic [FW-1:0]    fs_s1;
	logic             vld_s1;
	logic [FW-1:0]    fh_s2;
	logic [FW-1:0]    fs_s2;
	logic [FW-1:0]    qh_s2;
	logic [FW-1:0]    qs_s2;
	logic             vld_s2;
	logic [IDX_W-1:0] rh_q;
	logic [IDX_W-1:0] rs_q;
	logic             done_q;
	logic [FW-1:0]    fold_h;
	logic [FW-1:0]    fold_s;

	// bytes weighted by their position mod the divisor; sum stays below 2^18
	always_comb begin
		fold_h = FW'(key[7:0]) + FW'(key[15:8]) * FW'(WH1)
			+ FW'(key[23:16]) * FW'(WH2) + FW'(key[KEY_W-1:24]) * FW'(WH3);
		fold_s = FW'(key[7:0]) + FW'(key[15:8]) * FW'(WS1)
			+ FW'(key[23:16]) * FW'(WS2) + FW'(key[KEY_W-1:24]) * FW'(WS3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= load;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fh_s1 <= fold_h;
			fs_s1 <= fold_s;
		end
		if (vld_s1) begin
			fh_s2 <= fh_s1;
			fs_s2 <= fs_s1;
			qh_s2 <= FW'((PW'(fh_s1) * PW'(RH)) >> SH);
			qs_s2 <= FW'((PW'(fs_s1) * PW'(RS)) >> SH);
		end
		if (vld_s2) begin
			rh_q <= IDX_W'(fh_s2 - qh_s2 * FW'(MH));
			rs_q <= IDX_W'(fs_s2 - qs_s2 * FW'(MS));
		end
	end

	assign done = done_q;
	assign home = rh_q;
	assign step = rs_q + IDX_W'(1);

endmodule

>>> hdl/dht_store.sv
// Slot memory: key and tombstone flag per slot, valid bits for empty slots.
module dht_store #(
	parameter int TABLE_SIZE = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dht_pkg::mem_op_t              op,
	input  logic [$clog2(TABLE_SIZE)-1:0] addr,
	input  logic [dht_pkg::KEY_W-1:0]     wr_key,
	output logic [dht_pkg::KEY_W-1:0]     rd_key,
	output logic                          rd_del,
	output logic                          rd_vld
);
	import dht_pkg::*;

	logic [KEY_W:0]          mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0]   vld_q;
	logic [KEY_W:0]          rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (op.wr) begin
			mem[addr] <= {op.del, wr_key};
		end
		if (op.rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (op.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (op.rd) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	assign rd_key = rd_q[KEY_W-1:0];
	assign rd_del = rd_q[KEY_W];
	assign rd_vld = rd_vld_q;

endmodule

>>> test/double_hash_table_insert_delete_top_tb.sv
// Self-checking testbench for the double-hashing insert/delete hash table.
module double_hash_table_insert_delete_top_tb;
	import dht_pkg::*;

	localparam int TABLE_SIZE   = 11;
	localparam int RANDOM_ITEMS = 730;
	localparam int CYCLE_LIMIT  = 200000;

	class hash_table_scoreboard;
		typedef enum bit [1:0] {SLOT_EMPTY, SLOT_USED, SLOT_GONE} slot_state_t;
		typedef struct {
			logic [1:0]        outcome;
			logic [SLOT_W-1:0] slot;
		} table_reply_t;

		slot_state_t    state_of [TABLE_SIZE];
		bit [KEY_W-1:0] key_of [TABLE_SIZE];
		table_reply_t   pending_replies [$];
		int             mismatches;

		// Walks the double-hash probe path, updates the shadow table and queues the expected reply.
		function void note_request(logic cmd, logic [KEY_W-1:0] k);
			int unsigned  home;
			int unsigned  stride;
			int unsigned  idx;
			table_reply_t r;
			home      = 32'(k) % TABLE_SIZE;
			stride    = 1 + 32'(k) % (TABLE_SIZE - 1);
			r.outcome = (cmd == CMD_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
			r.slot    = '0;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				idx = (home + i * stride) % TABLE_SIZE;
				if (cmd == CMD_INSERT) begin
					if (state_of[idx] != SLOT_USED) begin
						key_of[idx]   = k;
						state_of[idx] = SLOT_USED;
						r.outcome     = OUT_INSERTED;
						r.slot        = idx[SLOT_W-1:0];
						break;
					end
				end else begin
					if (state_of[idx] == SLOT_USED && key_of[idx] == k) begin
						state_of[idx] = SLOT_GONE;
						r.outcome     = OUT_DELETED;
						r.slot        = idx[SLOT_W-1:0];
						break;
					end
					if (state_of[idx] == SLOT_EMPTY)
						break;
				end
			end
			pending_replies.push_back(r);
		endfunction

		function void check_result(logic [1:0] oc, logic [SLOT_W-1:0] sl);
			table_reply_t r;
			if (pending_replies.size() == 0) begin
				$error("result with no transaction pending: outcome=%0d slot=%0d", oc, sl);
				mismatches++;
				return;
			end
			r = pending_replies.pop_front();
			if (oc !== r.outcome) begin
				$error("outcome: expected %0d, actual %0d", r.outcome, oc);
				mismatches++;
			end
			if (sl !== r.slot) begin
				$error("slot: expected %0d, actual %0d", r.slot, sl);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	logic              command = CMD_INSERT;
	logic [KEY_W-1:0]  key     = '0;
	logic              busy;
	logic              done;
	logic [1:0]        outcome;
	logic [SLOT_W-1:0] slot;

	hash_table_scoreboard sb = new;
	int                   cycle_count = 0;
	int                   burst_left  = 0;
	logic [KEY_W-1:0]     recent_keys [$];

	double_hash_table_insert_delete_top #(
		.TABLE_SIZE(TABLE_SIZE)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.command(command),
		.key    (key),
		.done   (done),
		.outcome(outcome),
		.slot   (slot)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("double_hash_table_insert_delete_top verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done !== 1'b0)
				sb.check_result(outcome, slot);
			if (start && busy === 1'b0)
				sb.note_request(command, key);
		end
	end

	// One transaction; start stays high inside a burst, drops for any nonzero gap after it.
	task automatic issue(input logic cmd, input logic [KEY_W-1:0] k);
		int gap;
		start   <= 1'b1;
		command <= cmd;
		key     <= k;
		do @(posedge clk); while (busy !== 1'b0);
		if (cmd == CMD_INSERT) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > 16)
				void'(recent_keys.pop_front());
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0, 1: begin
				if (recent_keys.size() != 0)
					return recent_keys[$urandom_range(recent_keys.size() - 1)];
				return KEY_W'($urandom_range(40));
			end
			2: return KEY_W'($urandom_range(40));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	initial begin
		logic [KEY_W-1:0] fill_keys [11];
		int               insert_pct;
		fill_keys = '{31'd11, 31'd22, 31'd33, 31'd5, 31'd16, 31'd27, 31'd100, 31'd7,
			31'd1234567, 31'h55555555, 31'h2AAAAAAA};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// duplicates, tombstone skipping, extremes of the key
		issue(CMD_INSERT, '0);
		issue(CMD_INSERT, '1);
		issue(CMD_INSERT, '0);
		issue(CMD_DELETE, '0);
		issue(CMD_DELETE, '0);
		issue(CMD_DELETE, '0);
		issue(CMD_DELETE, '1);
		// fill over tombstones, then full table and exhausted search
		foreach (fill_keys[i])
			issue(CMD_INSERT, fill_keys[i]);
		issue(CMD_INSERT, 31'd44);
		issue(CMD_DELETE, 31'd999);
		issue(CMD_DELETE, 31'd22);
		issue(CMD_INSERT, 31'd22);

		insert_pct = 30;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				insert_pct = (insert_pct == 30) ? 75 : 30;
			issue(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE, pick_key());
		end

		start <= 1'b0;
		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (2 * (TABLE_SIZE + 10)) @(posedge clk);
		if (sb.mismatches == 0)
			$display("double_hash_table_insert_delete_top verification clean");
		else
			$display("double_hash_table_insert_delete_top verification failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/dht_pkg.sv
hdl/dht_hash.sv
hdl/dht_store.sv
hdl/double_hash_table_insert_delete_top.sv
test/double_hash_table_insert_delete_top_tb.sv
